// ===== rtl/min_covering_window_macros.svh =====
// Assertion macros shared by the min_covering_window RTL.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef MIN_COVERING_WINDOW_MACROS_SVH
`define MIN_COVERING_WINDOW_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define MCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MCW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mcw_pkg.sv =====
// Shared types and constants for the min_covering_window block.
// No dependencies; every other RTL file but the macro header imports it.
package mcw_pkg;

    localparam int WINDOW_DEPTH_DEF  = 4096;
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int COUNT_WIDTH_DEF   = 16;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int CHAR_SPAN = 1 << CHAR_W;
    localparam int POS_W     = 32;
    localparam int LEN_W     = 13;

    localparam logic [LEN_W-1:0] LEN_MAX = 13'd8191;

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_TARGET = 2'd0;
    localparam opcode_t OP_SOURCE = 2'd1;
    localparam opcode_t OP_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT_RD,
        S_TGT_WR,
        S_CLEAR,
        S_SRC,
        S_EV_CH,
        S_EV_WR,
        S_ADD_RD,
        S_ADD_WR,
        S_SHR_CNT,
        S_SHR_DEC,
        S_BEST,
        S_DONE
    } state_t;

    // Control of the count table port
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } cnt_ctl_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] best_start;
        logic [LEN_W-1:0] best_length;
        logic             overflow;
    } result_t;

endpackage

// ===== rtl/min_covering_window.sv =====
// Top level of the minimum covering window search.
// Instantiates mcw_core, mcw_count_mem, mcw_char_mem; uses mcw_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, opcode, char_code) takes one beat per
//   command: load a target character, push a source character, or clear the
//   job. Every input beat yields exactly one result beat on the output
//   channel (out_valid/out_ready, found, best_start, best_length, overflow)
//   holding the best window seen so far in the job.
//   Steps from input accept to result valid: a target load reads, then writes
//   its count row; a clear passes through S_CLEAR; an unknown opcode goes to
//   S_DONE. A source character evicts the oldest character if the window is
//   full, adds itself with a read and a write of its count row, shrinks from
//   the left edge, dropping each surplus leftmost character, until a needed
//   character or an empty window stops it, and then updates the best window.
//   The next beat is taken in the cycle after the result is registered; over
//   a job the shrink steps amortize to about one per source character. The
//   steps follow from the single read-modify-write port of the count table
//   and the registered reads of the character buffer and the count table.
//   Reset (rst_n low, asynchronous) empties all tables and counters, with
//   the count table cleared at once through row valid bits; no clearing
//   pass is needed. While the receiver stalls, the result is held in the
//   output register and one more input beat is accepted and processed.
module min_covering_window #(
    parameter int WINDOW_DEPTH  = mcw_pkg::WINDOW_DEPTH_DEF,
    parameter int ALPHABET_SIZE = mcw_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_WIDTH   = mcw_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mcw_pkg::opcode_t            opcode,
    input  logic [mcw_pkg::CHAR_W-1:0]  char_code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [mcw_pkg::POS_W-1:0]   best_start,
    output logic [mcw_pkg::LEN_W-1:0]   best_length,
    output logic                        overflow
);
    import mcw_pkg::*;

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int DW = 2 * COUNT_WIDTH;

    // Count table port
    cnt_ctl_t      cnt_ctl;
    logic [AW-1:0] cnt_rd_addr;
    logic [AW-1:0] cnt_wr_addr;
    logic [DW-1:0] cnt_wr_data;
    logic [DW-1:0] cnt_rd_data;

    // Character buffer port
    logic          chr_wr_en;
    logic [IW-1:0] chr_wr_addr;
    logic [AW-1:0] chr_wr_data;
    logic          chr_rd_en;
    logic [IW-1:0] chr_rd_addr;
    logic [AW-1:0] chr_rd_data;

    // Result handoff between core and output register
    logic          fin;
    logic          slot_free;
    result_t       res;
    result_t       res_reg;
    logic          out_valid_reg, out_valid_next;

    mcw_core #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_WIDTH   (COUNT_WIDTH),
        .AW            (AW),
        .IW            (IW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .char_code   (char_code),
        .slot_free   (slot_free),
        .fin         (fin),
        .res         (res),
        .cnt_ctl     (cnt_ctl),
        .cnt_rd_addr (cnt_rd_addr),
        .cnt_wr_addr (cnt_wr_addr),
        .cnt_wr_data (cnt_wr_data),
        .cnt_rd_data (cnt_rd_data),
        .chr_wr_en   (chr_wr_en),
        .chr_wr_addr (chr_wr_addr),
        .chr_wr_data (chr_wr_data),
        .chr_rd_en   (chr_rd_en),
        .chr_rd_addr (chr_rd_addr),
        .chr_rd_data (chr_rd_data)
    );

    mcw_count_mem #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (AW),
        .DW    (DW)
    ) u_count_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cnt_ctl),
        .rd_addr (cnt_rd_addr),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_data (cnt_rd_data)
    );

    mcw_char_mem #(
        .DEPTH (WINDOW_DEPTH),
        .IW    (IW),
        .AW    (AW)
    ) u_char_mem (
        .clk     (clk),
        .wr_en   (chr_wr_en),
        .wr_addr (chr_wr_addr),
        .wr_data (chr_wr_data),
        .rd_en   (chr_rd_en),
        .rd_addr (chr_rd_addr),
        .rd_data (chr_rd_data)
    );

    // Output register: free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (fin && slot_free)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = res_reg.found;
    assign best_start  = res_reg.best_start;
    assign best_length = res_reg.best_length;
    assign overflow    = res_reg.overflow;

endmodule

// ===== rtl/mcw_count_mem.sv =====
// Per-character count table: {target count, window count} in one word.
// Row valid bits clear the whole table at once. Uses mcw_pkg.
module mcw_count_mem #(
    parameter int DEPTH = mcw_pkg::ALPHABET_SIZE_DEF,
    parameter int AW    = $clog2(mcw_pkg::ALPHABET_SIZE_DEF),
    parameter int DW    = 2 * mcw_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mcw_pkg::cnt_ctl_t ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DW-1:0]     wr_data,
    output logic [DW-1:0]     rd_data
);
    import mcw_pkg::*;

    logic [DW-1:0]    count_mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    q_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            q_reg <= count_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Unwritten rows read as zero
    assign rd_data = hit_reg ? q_reg : '0;

endmodule

// ===== rtl/mcw_char_mem.sv =====
// Circular buffer of window characters, one read and one write port.
// Read data registered. Uses mcw_pkg.
module mcw_char_mem #(
    parameter int DEPTH = mcw_pkg::WINDOW_DEPTH_DEF,
    parameter int IW    = $clog2(mcw_pkg::WINDOW_DEPTH_DEF),
    parameter int AW    = $clog2(mcw_pkg::ALPHABET_SIZE_DEF)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output logic [AW-1:0] rd_data
);
    import mcw_pkg::*;

    logic [AW-1:0] char_mem [DEPTH];
    logic [AW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= char_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mcw_core.sv =====
// Sequencer and datapath of the covering window search.
// Drives mcw_count_mem and mcw_char_mem. Uses mcw_pkg and the assertion macros.
`include "min_covering_window_macros.svh"

module mcw_core #(
    parameter int WINDOW_DEPTH  = mcw_pkg::WINDOW_DEPTH_DEF,
    parameter int ALPHABET_SIZE = mcw_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_WIDTH   = mcw_pkg::COUNT_WIDTH_DEF,
    parameter int AW            = $clog2(mcw_pkg::ALPHABET_SIZE_DEF),
    parameter int IW            = $clog2(mcw_pkg::WINDOW_DEPTH_DEF)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mcw_pkg::opcode_t            opcode,
    input  logic [mcw_pkg::CHAR_W-1:0]  char_code,
    input  logic                        slot_free,
    output logic                        fin,
    output mcw_pkg::result_t            res,
    output mcw_pkg::cnt_ctl_t           cnt_ctl,
    output logic [AW-1:0]               cnt_rd_addr,
    output logic [AW-1:0]               cnt_wr_addr,
    output logic [2*COUNT_WIDTH-1:0]    cnt_wr_data,
    input  logic [2*COUNT_WIDTH-1:0]    cnt_rd_data,
    output logic                        chr_wr_en,
    output logic [IW-1:0]               chr_wr_addr,
    output logic [AW-1:0]               chr_wr_data,
    output logic                        chr_rd_en,
    output logic [IW-1:0]               chr_rd_addr,
    input  logic [AW-1:0]               chr_rd_data
);
    import mcw_pkg::*;

    localparam int CW   = COUNT_WIDTH;
    localparam int LW   = $clog2(WINDOW_DEPTH + 1);
    localparam int CMPW = (LW > LEN_W) ? LW : LEN_W;

    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // Character reduction table, built at elaboration
    logic [AW-1:0] mod_tbl [CHAR_SPAN];

    for (genvar g = 0; g < CHAR_SPAN; g++)
    begin : g_mod
        assign mod_tbl[g] = AW'(g % ALPHABET_SIZE);
    end

    state_t            state_reg, state_next;
    logic [AW-1:0]     chr_reg, chr_next;
    logic [AW-1:0]     lchr_reg, lchr_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IW-1:0]     wr_idx_reg, wr_idx_next;
    logic [LW-1:0]     win_len_reg, win_len_next;
    logic [POS_W-1:0]  left_pos_reg, left_pos_next;
    logic [CW-1:0]     matched_reg, matched_next;
    logic [CW-1:0]     tgt_len_reg, tgt_len_next;
    logic [POS_W-1:0]  best_pos_reg, best_pos_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic              ovf_reg, ovf_next;

    logic [CW-1:0]     rd_tc;
    logic [CW-1:0]     rd_wc;
    logic              wc_le_tc;
    logic              win_full;
    logic              win_last;
    logic [IW-1:0]     rd_inc;
    logic [IW-1:0]     wr_inc;
    logic [CMPW-1:0]   win_ext;
    logic [LEN_W-1:0]  len_sat;

    assign rd_tc    = cnt_rd_data[2*CW-1:CW];
    assign rd_wc    = cnt_rd_data[CW-1:0];
    assign wc_le_tc = (rd_wc <= rd_tc);
    assign win_full = (win_len_reg == LW'(WINDOW_DEPTH));
    assign win_last = (win_len_reg == LW'(1));
    assign rd_inc   = (rd_idx_reg == IW'(WINDOW_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign wr_inc   = (wr_idx_reg == IW'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign win_ext  = CMPW'(win_len_reg);
    assign len_sat  = (win_ext > CMPW'(LEN_MAX)) ? LEN_MAX : LEN_W'(win_ext);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_TARGET: state_next = S_TGT_RD;
                        OP_SOURCE: state_next = S_SRC;
                        OP_CLEAR:  state_next = S_CLEAR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_TGT_RD:  state_next = S_TGT_WR;
            S_TGT_WR:  state_next = S_DONE;
            S_CLEAR:   state_next = S_DONE;
            S_SRC:     state_next = win_full ? S_EV_CH : S_ADD_RD;
            S_EV_CH:   state_next = S_EV_WR;
            S_EV_WR:   state_next = S_ADD_RD;
            S_ADD_RD:  state_next = S_ADD_WR;
            S_ADD_WR:  state_next = S_SHR_CNT;
            S_SHR_CNT: state_next = S_SHR_DEC;
            S_SHR_DEC:
            begin
                if (wc_le_tc || win_last)
                begin
                    state_next = S_BEST;
                end
                else
                begin
                    state_next = S_SHR_CNT;
                end
            end
            S_BEST:    state_next = S_DONE;
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        in_ready      = 1'b0;
        fin           = 1'b0;
        cnt_ctl       = '0;
        cnt_rd_addr   = chr_reg;
        cnt_wr_addr   = lchr_reg;
        cnt_wr_data   = cnt_rd_data;
        chr_wr_en     = 1'b0;
        chr_wr_addr   = wr_idx_reg;
        chr_wr_data   = chr_reg;
        chr_rd_en     = 1'b0;
        chr_rd_addr   = rd_idx_reg;
        chr_next      = chr_reg;
        lchr_next     = lchr_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        win_len_next  = win_len_reg;
        left_pos_next = left_pos_reg;
        matched_next  = matched_reg;
        tgt_len_next  = tgt_len_reg;
        best_pos_next = best_pos_reg;
        best_len_next = best_len_reg;
        ovf_next      = ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    chr_next = mod_tbl[char_code];
                end
            end
            S_TGT_RD:
            begin
                cnt_ctl.rd_en = 1'b1;
            end
            S_TGT_WR:
            begin
                cnt_ctl.wr_en = 1'b1;
                cnt_wr_addr   = chr_reg;
                if (rd_tc == CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    cnt_wr_data = {rd_tc + 1'b1, rd_wc};
                end
                if (tgt_len_reg == CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    tgt_len_next = tgt_len_reg + 1'b1;
                end
            end
            S_CLEAR:
            begin
                cnt_ctl.clr   = 1'b1;
                rd_idx_next   = '0;
                wr_idx_next   = '0;
                win_len_next  = '0;
                left_pos_next = '0;
                matched_next  = '0;
                tgt_len_next  = '0;
                best_pos_next = '0;
                best_len_next = '0;
                ovf_next      = 1'b0;
            end
            S_SRC:
            begin
                // Full window: fetch the leftmost character for eviction
                if (win_full)
                begin
                    ovf_next  = 1'b1;
                    chr_rd_en = 1'b1;
                end
            end
            S_EV_CH, S_SHR_CNT:
            begin
                cnt_ctl.rd_en = 1'b1;
                cnt_rd_addr   = chr_rd_data;
                lchr_next     = chr_rd_data;
            end
            S_EV_WR:
            begin
                cnt_ctl.wr_en = 1'b1;
                if (wc_le_tc && (matched_reg != '0))
                begin
                    matched_next = matched_reg - 1'b1;
                end
                if (rd_wc != '0)
                begin
                    cnt_wr_data = {rd_tc, rd_wc - 1'b1};
                end
                rd_idx_next   = rd_inc;
                left_pos_next = left_pos_reg + 1'b1;
                win_len_next  = win_len_reg - 1'b1;
            end
            S_ADD_RD:
            begin
                chr_wr_en     = 1'b1;
                wr_idx_next   = wr_inc;
                win_len_next  = win_len_reg + 1'b1;
                cnt_ctl.rd_en = 1'b1;
            end
            S_ADD_WR:
            begin
                cnt_ctl.wr_en = 1'b1;
                cnt_wr_addr   = chr_reg;
                if (rd_wc == CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    cnt_wr_data = {rd_tc, rd_wc + 1'b1};
                    if ((rd_wc + 1'b1) <= rd_tc)
                    begin
                        if (matched_reg == CNT_MAX)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            matched_next = matched_reg + 1'b1;
                        end
                    end
                end
                // Start the shrink pass at the left edge
                chr_rd_en = 1'b1;
            end
            S_SHR_DEC:
            begin
                if (!wc_le_tc)
                begin
                    cnt_ctl.wr_en = 1'b1;
                    cnt_wr_data   = {rd_tc, rd_wc - 1'b1};
                    rd_idx_next   = rd_inc;
                    left_pos_next = left_pos_reg + 1'b1;
                    win_len_next  = win_len_reg - 1'b1;
                    if (!win_last)
                    begin
                        chr_rd_en   = 1'b1;
                        chr_rd_addr = rd_inc;
                    end
                end
            end
            S_BEST:
            begin
                if ((tgt_len_reg != '0) && (matched_reg == tgt_len_reg)
                    && ((best_len_reg == '0) || (len_sat < best_len_reg)))
                begin
                    best_len_next = len_sat;
                    best_pos_next = left_pos_reg;
                end
            end
            S_DONE:
            begin
                fin = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            win_len_reg  <= '0;
            left_pos_reg <= '0;
            matched_reg  <= '0;
            tgt_len_reg  <= '0;
            best_pos_reg <= '0;
            best_len_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            win_len_reg  <= win_len_next;
            left_pos_reg <= left_pos_next;
            matched_reg  <= matched_next;
            tgt_len_reg  <= tgt_len_next;
            best_pos_reg <= best_pos_next;
            best_len_reg <= best_len_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg  <= chr_next;
        lchr_reg <= lchr_next;
    end

    assign res.found       = (best_len_reg != '0);
    assign res.best_start  = (best_len_reg != '0) ? best_pos_reg : '0;
    assign res.best_length = best_len_reg;
    assign res.overflow    = ovf_reg;

    `MCW_ASSERT_ALWAYS(a_win_len_bound, win_len_reg <= LW'(WINDOW_DEPTH), "window length past depth")
    `MCW_ASSERT_ALWAYS(a_matched_le_target, matched_reg <= tgt_len_reg, "matched count above target")
    `MCW_ASSERT_IMPL(a_cnt_port_split, cnt_ctl.rd_en, !cnt_ctl.wr_en && !cnt_ctl.clr, "count read overlaps write")
    `MCW_ASSERT_NEXT(a_clear_empties, state_reg == S_CLEAR, (win_len_reg == '0) && (matched_reg == '0) && (best_len_reg == '0), "clear left state behind")

endmodule

// ===== tb/mcw_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for min_covering_window: watches both channels, predicts each result beat.
// Depends on mcw_pkg for the opcode codes, the result layout and the default sizes.
module mcw_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  mcw_pkg::opcode_t           opcode,
    input  logic [mcw_pkg::CHAR_W-1:0] char_code,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       found,
    input  logic [mcw_pkg::POS_W-1:0]  best_start,
    input  logic [mcw_pkg::LEN_W-1:0]  best_length,
    input  logic                       overflow,
    output int                         fails,
    output int                         pending
);
    import mcw_pkg::*;

    localparam int          DEPTH   = WINDOW_DEPTH_DEF;
    localparam int          ALPHA   = ALPHABET_SIZE_DEF;
    localparam int unsigned CNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int unsigned LEN_CAP = int'(LEN_MAX);

    // Model state of the search job
    int unsigned      tgt_cnt [CHAR_SPAN];
    int unsigned      win_cnt [CHAR_SPAN];
    logic [CHAR_W-1:0] win_buf [DEPTH];
    int unsigned      lpos;
    int unsigned      match_cnt;
    int unsigned      tgt_len;
    int unsigned      best_at;
    int unsigned      best_w;
    logic             ovf;
    int unsigned      head;
    int unsigned      tail;
    int unsigned      fill;

    result_t          window_results [$];
    result_t          want;
    int               nbad;

    function automatic int unsigned wrap_next(int unsigned i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic void clear_job();
        for (int i = 0; i < CHAR_SPAN; i++)
        begin
            tgt_cnt[i] = 0;
            win_cnt[i] = 0;
        end
        lpos      = 0;
        match_cnt = 0;
        tgt_len   = 0;
        best_at   = 0;
        best_w    = 0;
        ovf       = 1'b0;
        head      = 0;
        tail      = 0;
        fill      = 0;
    endfunction

    // Drop the oldest character of a full window
    function automatic void evict_oldest();
        int unsigned c;
        c = win_buf[head] % ALPHA;
        if (win_cnt[c] <= tgt_cnt[c] && match_cnt > 0)
            match_cnt--;
        if (win_cnt[c] > 0)
            win_cnt[c]--;
        head = wrap_next(head);
        lpos++;
        fill--;
    endfunction

    function automatic void push_source(int unsigned c);
        int unsigned l;
        int unsigned len;
        if (fill >= DEPTH)
        begin
            ovf = 1'b1;
            evict_oldest();
        end
        win_buf[tail] = c[CHAR_W-1:0];
        tail = wrap_next(tail);
        fill++;

        if (win_cnt[c] >= CNT_MAX)
            ovf = 1'b1;
        else
        begin
            win_cnt[c]++;
            if (win_cnt[c] <= tgt_cnt[c])
            begin
                if (match_cnt >= CNT_MAX)
                    ovf = 1'b1;
                else
                    match_cnt++;
            end
        end

        // Shrink from the left while the leftmost character is in surplus
        while (fill > 0)
        begin
            l = win_buf[head] % ALPHA;
            if (win_cnt[l] <= tgt_cnt[l])
                break;
            win_cnt[l]--;
            head = wrap_next(head);
            lpos++;
            fill--;
        end

        if (tgt_len != 0 && match_cnt == tgt_len)
        begin
            len = (fill > LEN_CAP) ? LEN_CAP : fill;
            if (best_w == 0 || len < best_w)
            begin
                best_w  = len;
                best_at = lpos;
            end
        end
    endfunction

    function automatic result_t predict_window(opcode_t op, logic [CHAR_W-1:0] ch);
        int unsigned c;
        result_t     r;
        c = int'(ch) % ALPHA;
        case (op)
            OP_TARGET:
            begin
                if (tgt_cnt[c] >= CNT_MAX)
                    ovf = 1'b1;
                else
                    tgt_cnt[c]++;
                if (tgt_len >= CNT_MAX)
                    ovf = 1'b1;
                else
                    tgt_len++;
            end
            OP_SOURCE: push_source(c);
            OP_CLEAR:  clear_job();
            default:   ;
        endcase
        r.found       = (best_w != 0);
        r.best_start  = (best_w != 0) ? best_at : '0;
        r.best_length = best_w[LEN_W-1:0];
        r.overflow    = ovf;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_job();
            window_results.delete();
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                nbad = 0;
                if (window_results.size() == 0)
                begin
                    $error("result beat with nothing expected: found=%0d start=%0d length=%0d",
                           found, best_start, best_length);
                    nbad = 1;
                end
                else
                begin
                    want = window_results.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        nbad++;
                    end
                    if (best_start !== want.best_start)
                    begin
                        $error("best_start: expected %0d, got %0d", want.best_start, best_start);
                        nbad++;
                    end
                    if (best_length !== want.best_length)
                    begin
                        $error("best_length: expected %0d, got %0d",
                               want.best_length, best_length);
                        nbad++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", want.overflow, overflow);
                        nbad++;
                    end
                end
                fails <= fails + nbad;
            end
            if (in_valid && in_ready)
                window_results.push_back(predict_window(opcode, char_code));
            pending <= window_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the min_covering_window block.
// Depends on mcw_pkg, the block itself and the scoreboard in mcw_checker.sv.
module tb_top;
    import mcw_pkg::*;

    // Opcode 3 has no meaning; the block must only echo its current result
    localparam opcode_t OP_UNUSED = 2'd3;

    // Watchdog limit, set with a wide margin over the slowest run
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_BEATS = 750;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    opcode_t           opcode    = OP_TARGET;
    logic [CHAR_W-1:0] char_code = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              found;
    logic [POS_W-1:0]  best_start;
    logic [LEN_W-1:0]  best_length;
    logic              overflow;

    int  fails;
    int  pending;
    int  cycle_cnt  = 0;
    int  beats_sent = 0;
    int  jobs_run   = 0;
    int  drains     = 0;
    bit  stall_on   = 1'b1;

    min_covering_window DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .best_start  (best_start),
        .best_length (best_length),
        .overflow    (overflow)
    );

    mcw_checker CHK (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .best_start  (best_start),
        .best_length (best_length),
        .overflow    (overflow),
        .fails       (fails),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one command beat. With stall_on set, idle a random gap first, then
    // raise valid with the payload at the falling edge and hold both until the
    // block takes the beat at a rising edge. Valid is lowered only by a later
    // gap or a drain, so back-to-back beats keep it high without a glitch.
    task automatic send_beat(opcode_t op, logic [CHAR_W-1:0] ch);
        int gap;
        gap = stall_on ? $urandom_range(0, 3) : 0;
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid  <= 1'b1;
        opcode    <= op;
        char_code <= ch;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        drains++;
    endtask

    // One random job: mostly a clear, a few target characters, then a run of
    // source characters drawn from a tiny per-job alphabet so that covering
    // windows form often. Mix in mid-job targets, unused opcodes, stray bytes
    // and fully random commands as noise.
    task automatic run_random_job();
        logic [CHAR_W-1:0] alpha [5];
        int                n_alpha;
        int                n_tgt;
        int                n_src;
        int                roll;
        n_alpha = $urandom_range(2, 5);
        for (int i = 0; i < n_alpha; i++)
            alpha[i] = CHAR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 7) != 0)
            send_beat(OP_CLEAR, CHAR_W'($urandom_range(0, 255)));
        // A zero count adds no target characters before the source run
        n_tgt = $urandom_range(0, 5);
        for (int i = 0; i < n_tgt; i++)
            send_beat(OP_TARGET, alpha[$urandom_range(0, n_alpha - 1)]);
        n_src = $urandom_range(4, 40);
        for (int i = 0; i < n_src; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_beat(OP_TARGET, alpha[$urandom_range(0, n_alpha - 1)]);
            else if (roll < 5)
                send_beat(OP_UNUSED, CHAR_W'($urandom_range(0, 255)));
            else if (roll < 8)
                send_beat(opcode_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
            else if (roll < 14)
                send_beat(OP_SOURCE, CHAR_W'($urandom_range(0, 255)));
            else
                send_beat(OP_SOURCE, alpha[$urandom_range(0, n_alpha - 1)]);
        end
    endtask

    // Receiver: before each result beat, with stall_on set, hold ready low for a
    // random gap, then hold ready high until a result is taken.
    initial
    begin : result_sink
        int gap;
        wait (rst_n);
        forever
        begin
            gap = stall_on ? $urandom_range(0, 3) : 0;
            repeat (gap) @(negedge clk) out_ready <= 1'b0;
            @(negedge clk) out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int rand_start;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty target: source characters alone must never report a window
        send_beat(OP_SOURCE, 8'h41);
        send_beat(OP_SOURCE, 8'hFF);
        // Unused opcode at both byte extremes: result unchanged
        send_beat(OP_UNUSED, 8'h00);
        send_beat(OP_UNUSED, 8'hFF);

        // Three distinct targets, two at the byte extremes, then a source string
        // with several covering windows, two of equal length (earliest wins)
        send_beat(OP_CLEAR, 8'h00);
        send_beat(OP_TARGET, 8'h00);
        send_beat(OP_TARGET, 8'hFF);
        send_beat(OP_TARGET, 8'h80);
        send_beat(OP_SOURCE, 8'hFF);
        send_beat(OP_SOURCE, 8'h12);
        send_beat(OP_SOURCE, 8'h00);
        send_beat(OP_SOURCE, 8'h34);
        send_beat(OP_SOURCE, 8'h80);
        send_beat(OP_SOURCE, 8'h00);
        send_beat(OP_SOURCE, 8'hFF);
        send_beat(OP_SOURCE, 8'h80);
        // Target grows mid-job; matched count is not rescanned
        send_beat(OP_TARGET, 8'h00);
        send_beat(OP_SOURCE, 8'h00);
        send_beat(OP_SOURCE, 8'h7F);

        // Repeated target character
        send_beat(OP_CLEAR, 8'hFF);
        send_beat(OP_TARGET, 8'h07);
        send_beat(OP_TARGET, 8'h07);
        send_beat(OP_SOURCE, 8'h07);
        send_beat(OP_SOURCE, 8'h05);
        send_beat(OP_SOURCE, 8'h07);
        send_beat(OP_SOURCE, 8'h07);
        drain_results();

        // Random jobs; about one in four runs without idling
        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS)
        begin
            stall_on = ($urandom_range(0, 3) != 0);
            run_random_job();
            jobs_run++;
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end
        stall_on = 1'b1;

        // Drop valid, wait out every result, then a short quiet tail
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d command beats: empty, repeated and mid-job targets, tie windows,",
                 beats_sent);
        $display("and %0d random jobs with %0d full drains, in %0d cycles",
                 jobs_run, drains, cycle_cnt);
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
